// ===== design/lzw_pkg.sv =====
// Shared types for the LZW chunk decoder: item structs, result codes and
// the command/status structs between the controller and the datapath.
// No dependencies.
package lzw_pkg;

  localparam int unsigned CodeBits  = 12;
  localparam int unsigned StackAw   = 12;
  localparam logic [12:0] ClearCode = 13'h100;
  localparam logic [3:0]  MinWidth  = 4'd9;
  localparam logic [3:0]  MaxWidth  = 4'd12;

  // result codes
  localparam logic [2:0] ST_BYTE  = 3'd0;
  localparam logic [2:0] ST_TAKEN = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_BAD   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        chunk_start;
    logic [12:0] chunk_out_len;
    logic        restart_codes;
    logic        clear_table;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       end_of_chunk;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH,
    OP_TAKE,
    OP_RD_CODE,
    OP_WALK,
    OP_FIX,
    OP_ADD
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       pop;
    logic       out_load;
    logic [2:0] out_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic kind;
    logic full;
    logic left_zero;
    logic scnt_zero;
    logic short_bits;
    logic is_clear;
    logic is_bad;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/lzw_chunk_decompressor.sv =====
// Top level of the LZW chunk decoder: controller plus datapath.
// Depends on lzw_pkg, lzw_ctrl and lzw_dp.
//
// Pull-driven LZW decoder, 9 to 12 bit codes packed LSB first. An item
// either pushes one compressed byte (result "byte accepted" or
// "accumulator full") or pulls one decompressed byte (result "byte out",
// "no byte yet" or "bad code"). One item is handled at a time; the next
// item is taken as soon as the controller is back in idle, even while the
// previous result still waits in the output register. A push goes
// through decode to send; a pull with bytes already on the string stack
// pops one and sends it; a pull outside a chunk goes straight to send. A
// pull that needs a new code takes codes, once more per clear code
// consumed, and goes to send on too few bits or a bad code; else it reads
// the code's entry, walks the chain onto the string stack, fixes up and
// adds table entries, pops and sends. The chain walk dominates: the
// dictionary has one read port and each link needs one registered read,
// so links are read one at a time. The root entries are logic, not memory, and
// nothing ever rewrites them, so the clear_table flag has no work to do
// and the block needs no clearing pass after reset. Dictionary links are
// only read at codes no higher than the next entry, all of which have
// been written since reset, so the memories need no initialization.
module lzw_chunk_decompressor #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned CHUNK_BYTES   = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lzw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lzw_pkg::out_item_t out_item_o
);
  import lzw_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lzw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lzw_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CHUNK_BYTES   (CHUNK_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== design/lzw_ctrl.sv =====
// Controller FSM of the LZW chunk decoder: sequences push, code take,
// chain walk, table update, pop and result send. Depends on lzw_pkg.
module lzw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lzw_pkg::dp_stat_t stat_i,
  output lzw_pkg::ctrl_cmd_t cmd_o
);
  import lzw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_TAKE, S_RD, S_WALK, S_FIX, S_ADD, S_POP, S_SEND
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] st_q, st_d;

  always_comb begin
    state_d        = state_q;
    st_d           = st_q;
    cmd_o          = '0;
    cmd_o.op       = OP_NONE;
    cmd_o.out_status = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        if (!stat_i.kind) begin
          cmd_o.op = OP_PUSH;
          st_d     = stat_i.full ? ST_FULL : ST_TAKEN;
          state_d  = S_SEND;
        end else if (stat_i.left_zero) begin
          st_d    = ST_EMPTY;
          state_d = S_SEND;
        end else if (stat_i.scnt_zero) begin
          state_d = S_TAKE;
        end else begin
          state_d = S_POP;
        end
      end
      S_TAKE: begin
        if (stat_i.short_bits) begin
          st_d    = ST_EMPTY;
          state_d = S_SEND;
        end else begin
          cmd_o.op = OP_TAKE;
          if (stat_i.is_clear) begin
            state_d = S_TAKE;
          end else if (stat_i.is_bad) begin
            st_d    = ST_BAD;
            state_d = S_SEND;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        cmd_o.op = OP_RD_CODE;
        state_d  = S_WALK;
      end
      S_WALK: begin
        cmd_o.op = OP_WALK;
        if (stat_i.walk_done) state_d = S_FIX;
      end
      S_FIX: begin
        cmd_o.op = OP_FIX;
        state_d  = S_ADD;
      end
      S_ADD: begin
        cmd_o.op = OP_ADD;
        state_d  = S_POP;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        st_d      = ST_BYTE;
        state_d   = S_SEND;
      end
      S_SEND: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_EMPTY;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

endmodule

// ===== design/lzw_dp.sv =====
// Datapath of the LZW chunk decoder: bit accumulator, code width and next
// entry, dictionary and string stack memories, output register.
// Depends on lzw_pkg.
module lzw_dp #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned CHUNK_BYTES   = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lzw_pkg::in_item_t   in_item_i,
  input  lzw_pkg::ctrl_cmd_t  cmd_i,
  output lzw_pkg::dp_stat_t   stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lzw_pkg::out_item_t  out_item_o
);
  import lzw_pkg::*;

  localparam int unsigned Aw = $clog2(TABLE_ENTRIES);
  localparam logic [12:0] TableLim = 13'(TABLE_ENTRIES);
  localparam logic [13:0] ChunkLim = 14'(CHUNK_BYTES);

  // memories: link = {depth, prev}, char separate for char-only fixups
  logic [23:0] link_mem [TABLE_ENTRIES];
  logic [7:0]  char_mem [TABLE_ENTRIES];
  logic [7:0]  stk_mem  [2**StackAw];

  in_item_t    item_q;
  logic [23:0] acc_q;
  logic [4:0]  held_q;
  logic [12:0] next_q;
  logic [3:0]  width_q;
  logic [12:0] scnt_q;
  logic [12:0] left_q;
  logic        eoc_q;
  logic [11:0] code_q, depth_q, walk_i_q;
  logic [7:0]  first_q;
  logic [23:0] link_rd_q;
  logic [7:0]  char_rd_q, root_lo_q, stk_rd_q;
  logic        root_q;
  logic        out_valid_q;
  out_item_t   out_q;

  // current table entry from the registered read (roots are logic)
  logic [11:0] ent_depth, ent_prev, depth_eff;
  logic [7:0]  ent_char;
  assign ent_depth = root_q ? 12'd0 : link_rd_q[23:12];
  assign ent_prev  = root_q ? 12'd0 : link_rd_q[11:0];
  assign ent_char  = root_q ? root_lo_q : char_rd_q;
  assign depth_eff = (walk_i_q == 12'd0) ? ent_depth : depth_q;

  logic        walk_done;
  assign walk_done = (walk_i_q == depth_eff);

  // code extraction
  logic [12:0] mask;
  logic [11:0] code_now;
  logic [12:0] next_p1;
  assign mask     = (13'd1 << width_q) - 13'd1;
  assign code_now = acc_q[11:0] & mask[11:0];
  assign next_p1  = next_q + 13'd1;

  // push base values after chunk start
  logic [23:0] base_acc;
  logic [4:0]  base_held;
  logic        full;
  assign base_acc  = item_q.chunk_start ? 24'd0 : acc_q;
  assign base_held = item_q.chunk_start ? 5'd0 : held_q;
  assign full      = (base_held > 5'd16);

  logic        out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    stat_o.kind       = item_q.kind;
    stat_o.full       = full;
    stat_o.left_zero  = (left_q == 13'd0);
    stat_o.scnt_zero  = (scnt_q == 13'd0);
    stat_o.short_bits = ({1'b0, held_q} < {2'b0, width_q});
    stat_o.is_clear   = ({1'b0, code_now} == ClearCode);
    stat_o.is_bad     = ({1'b0, code_now} > next_q) || (next_p1 >= TableLim);
    stat_o.walk_done  = walk_done;
    stat_o.out_free   = out_free;
  end

  // dictionary read address
  logic        rd_en;
  logic [11:0] rd_addr;
  assign rd_en   = (cmd_i.op == OP_RD_CODE) || ((cmd_i.op == OP_WALK) && !walk_done);
  assign rd_addr = (cmd_i.op == OP_RD_CODE) ? code_q : ent_prev;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      link_rd_q <= link_mem[rd_addr[Aw-1:0]];
      char_rd_q <= char_mem[rd_addr[Aw-1:0]];
      root_q    <= (rd_addr < 12'd256);
      root_lo_q <= rd_addr[7:0];
    end
    if (cmd_i.op == OP_FIX) begin
      char_mem[next_q[Aw-1:0]] <= first_q;
    end
    if (cmd_i.op == OP_ADD) begin
      char_mem[next_p1[Aw-1:0]] <= first_q;
      link_mem[next_p1[Aw-1:0]] <= {depth_q + 12'd1, code_q};
    end
  end

  // string stack
  logic [12:0] scnt_m1;
  assign scnt_m1 = scnt_q - 13'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WALK) stk_mem[walk_i_q[StackAw-1:0]] <= ent_char;
    if (cmd_i.pop) stk_rd_q <= stk_mem[scnt_m1[StackAw-1:0]];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) item_q <= in_item_i;
    if (cmd_i.op == OP_TAKE) code_q <= code_now;
    if (cmd_i.op == OP_RD_CODE) walk_i_q <= 12'd0;
    if (cmd_i.op == OP_WALK) begin
      if (walk_i_q == 12'd0) depth_q <= ent_depth;
      if (walk_done) first_q <= ent_char;
      else walk_i_q <= walk_i_q + 12'd1;
    end
    if (cmd_i.out_load) begin
      out_q.status       <= cmd_i.out_status;
      out_q.out_byte     <= (cmd_i.out_status == ST_BYTE) ? stk_rd_q : 8'd0;
      out_q.end_of_chunk <= (cmd_i.out_status == ST_BYTE) && eoc_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      held_q      <= '0;
      next_q      <= ClearCode;
      width_q     <= MinWidth;
      scnt_q      <= '0;
      left_q      <= '0;
      eoc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_PUSH: begin
          if (item_q.chunk_start) begin
            scnt_q <= '0;
            left_q <= ({1'b0, item_q.chunk_out_len} > ChunkLim) ?
                      ChunkLim[12:0] : item_q.chunk_out_len;
            if (item_q.restart_codes) begin
              next_q  <= ClearCode;
              width_q <= MinWidth;
            end
          end
          if (full) begin
            acc_q  <= base_acc;
            held_q <= base_held;
          end else begin
            acc_q  <= base_acc | ({16'd0, item_q.data_byte} << base_held);
            held_q <= base_held + 5'd8;
          end
        end
        OP_TAKE: begin
          acc_q  <= acc_q >> width_q;
          held_q <= held_q - {1'b0, width_q};
          if ({1'b0, code_now} == ClearCode) begin
            next_q  <= ClearCode;
            width_q <= MinWidth;
          end else if ((next_p1 >= mask) && (width_q < MaxWidth)) begin
            width_q <= width_q + 4'd1;
          end
        end
        OP_ADD: begin
          next_q <= next_p1;
          scnt_q <= {1'b0, depth_q} + 13'd1;
        end
        default: ;
      endcase
      if (cmd_i.pop) begin
        left_q <= left_q - 13'd1;
        if (left_q == 13'd1) begin
          scnt_q <= '0;
          acc_q  <= '0;
          held_q <= '0;
          eoc_q  <= 1'b1;
        end else begin
          scnt_q <= scnt_m1;
          eoc_q  <= 1'b0;
        end
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== design/lzw_chk.sv =====
// Port-level checker for the LZW chunk decoder, bound to the top level.
// Depends on lzw_pkg and lzw_chunk_decompressor.
module lzw_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lzw_pkg::out_item_t out_item_o
);
  import lzw_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // only byte results carry data
  a_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != ST_BYTE) |->
      (out_item_o.out_byte == 8'd0) && !out_item_o.end_of_chunk)
    else $error("data on non-byte result");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status <= ST_FULL))
    else $error("status out of range");

  // one item at a time: an accept is followed by a busy cycle
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("back to back accept");

endmodule

bind lzw_chunk_decompressor lzw_chk u_lzw_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== dv/tb_lzw_chunk_decompressor.sv =====
// Testbench for lzw_chunk_decompressor: random-stall handshakes, self-checking scoreboard.
// Depends on lzw_pkg and the design files only; stimulus mixes valid and bad LZW codes.
module tb_lzw_chunk_decompressor;
  import lzw_pkg::*;

  localparam int unsigned TableSize = 4096;
  localparam int unsigned ChunkMax  = 4096;

  // Bit-accurate behavior of the decoder. One copy plans the stimulus, one predicts.
  class lzw_decoder_model;
    bit [31:0]   dict [TableSize];
    bit [7:0]    chars [TableSize];
    int unsigned next_code, width, acc, held, depth_left, left;

    function void load_roots();
      for (int i = 0; i < 256; i++) dict[i] = i << 12;
      dict[ClearCode] = '0;
    endfunction

    function void clear_all();
      for (int i = 0; i < TableSize; i++) begin
        dict[i]  = '0;
        chars[i] = '0;
      end
      load_roots();
      next_code  = ClearCode;
      width      = MinWidth;
      acc        = 0;
      held       = 0;
      depth_left = 0;
      left       = 0;
    endfunction

    // Moves one code's string onto the char stack; returns a status code.
    function logic [2:0] take_code();
      int unsigned mask, code, depth, walk;
      forever begin
        mask = (1 << width) - 1;
        if (held < width) return ST_EMPTY;
        code = acc & mask;
        acc  = (acc >> width) & 24'hffffff;
        held -= width;
        if (next_code + 1 >= mask && width < MaxWidth) width++;
        if (code == ClearCode) begin
          next_code = ClearCode;
          width     = MinWidth;
        end else begin
          break;
        end
      end
      if (code > next_code || next_code + 1 >= TableSize) return ST_BAD;
      depth = (dict[code & 'hfff] >> 20) & 'hfff;
      walk  = code;
      for (int i = 0; i <= depth; i++) begin
        walk = dict[walk & 'hfff];
        chars[i & 'hfff] = (walk >> 12) & 'hff;
      end
      depth_left = depth + 1;
      dict[next_code & 'hfff] = (dict[next_code & 'hfff] & ~32'hff000) | (walk & 'hff000);
      dict[(next_code + 1) & 'hfff] = (((depth + 1) & 'hfff) << 20) | (walk & 'hff000) | code;
      next_code++;
      return ST_BYTE;
    endfunction

    function out_item_t step(in_item_t it);
      out_item_t  res;
      logic [2:0] st;
      res = '0;
      if (it.kind == 1'b0) begin
        if (it.chunk_start) begin
          acc        = 0;
          held       = 0;
          depth_left = 0;
          left       = (it.chunk_out_len > ChunkMax) ? ChunkMax : it.chunk_out_len;
          if (it.restart_codes) begin
            next_code = ClearCode;
            width     = MinWidth;
          end
          if (it.clear_table) load_roots();
        end
        if (held > 16) begin
          res.status = ST_FULL;
          return res;
        end
        acc  = (acc | (it.data_byte << held)) & 24'hffffff;
        held += 8;
        res.status = ST_TAKEN;
        return res;
      end
      if (left == 0) begin
        res.status = ST_EMPTY;
        return res;
      end
      if (depth_left == 0) begin
        st = take_code();
        if (st != ST_BYTE) begin
          res.status = st;
          return res;
        end
      end
      depth_left--;
      res.status   = ST_BYTE;
      res.out_byte = chars[depth_left & 'hfff];
      left--;
      if (left == 0) begin
        depth_left = 0;
        acc        = 0;
        held       = 0;
        res.end_of_chunk = 1'b1;
      end
      return res;
    endfunction
  endclass

  class lzw_scoreboard;
    lzw_decoder_model decoder;
    out_item_t        expected_q[$];
    int               errors;

    function new();
      decoder = new();
      decoder.clear_all();
      errors = 0;
    endfunction

    function void note_input(in_item_t it);
      expected_q.push_back(decoder.step(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
        errors++;
      end
      if (got.out_byte !== exp.out_byte) begin
        $display("%0t: out_byte exp %h got %h", $time, exp.out_byte, got.out_byte);
        errors++;
      end
      if (got.end_of_chunk !== exp.end_of_chunk) begin
        $display("%0t: end_of_chunk exp %b got %b", $time, exp.end_of_chunk, got.end_of_chunk);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  lzw_chunk_decompressor uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  lzw_scoreboard    sb = new();
  lzw_decoder_model planner = new();
  in_item_t         stim_q[$];
  bit               stim_done = 1'b0;

  // encoder-side mirror of code width and next entry, plus pending packed bits
  int unsigned enc_next, enc_width, pack_bits, pack_cnt;

  function void add_item(in_item_t it);
    void'(planner.step(it));
    stim_q.push_back(it);
  endfunction

  function in_item_t noise_fields();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    return it;
  endfunction

  // Appends one code, LSB first, tracking width growth the way the decoder does.
  function void pack_code();
    int unsigned code, mask, r;
    mask = (1 << enc_width) - 1;
    r = $urandom_range(99);
    if (r < 3 && enc_next + 1 <= mask)
      code = $urandom_range(mask, enc_next + 1);       // bad code
    else if (r < 8)
      code = ClearCode;
    else if (r < 20 && enc_next > ClearCode)
      code = enc_next;                                 // KwKwK
    else if (r < 50 && enc_next > ClearCode + 1)
      code = $urandom_range(enc_next - 1,
                            (enc_next > ClearCode + 9) ? enc_next - 8 : ClearCode + 1);
    else
      code = $urandom_range(255);
    pack_bits |= code << pack_cnt;
    pack_cnt  += enc_width;
    if (enc_next + 1 >= mask && enc_width < MaxWidth) enc_width++;
    if (code == ClearCode) begin
      enc_next  = ClearCode;
      enc_width = MinWidth;
    end else if (code <= enc_next && enc_next + 1 < TableSize) begin
      enc_next++;
    end
  endfunction

  function logic [7:0] stream_byte();
    logic [7:0] b;
    while (pack_cnt < 8) pack_code();
    b = pack_bits & 'hff;
    pack_bits >>= 8;
    pack_cnt  -= 8;
    return b;
  endfunction

  // One chunk: start push, then pulls, pushing when the decoder runs short of bits and at random.
  function void make_chunk(int unsigned len, bit restart, bit clr, int cap);
    in_item_t it;
    enc_next  = restart ? ClearCode : planner.next_code;
    enc_width = restart ? MinWidth : planner.width;
    pack_bits = 0;
    pack_cnt  = 0;
    it = noise_fields();
    it.kind = 1'b0;
    it.chunk_start = 1'b1;
    it.chunk_out_len = len;
    it.restart_codes = restart;
    it.clear_table = clr;
    it.data_byte = stream_byte();
    add_item(it);
    for (int n = 0; n < cap && planner.left != 0; n++) begin
      it = noise_fields();
      it.chunk_start = 1'b0;
      if (planner.held > 16 && $urandom_range(99) < 3) begin
        it.kind = 1'b0;                     // refused, stream stays intact
      end else if (planner.held <= 16 &&
                   ((planner.depth_left == 0 && planner.held < planner.width) ||
                    $urandom_range(99) < 15)) begin
        it.kind = 1'b0;
        it.data_byte = stream_byte();
      end else begin
        it.kind = 1'b1;
      end
      add_item(it);
    end
  endfunction

  function void push_raw(logic [7:0] b, bit start);
    in_item_t it;
    it = '0;
    it.data_byte = b;
    it.chunk_start = start;
    it.chunk_out_len = 13'd5;
    it.restart_codes = 1'b1;
    add_item(it);
  endfunction

  function void pull_once();
    in_item_t it;
    it = noise_fields();
    it.kind = 1'b1;
    add_item(it);
  endfunction

  function void build_stimulus();
    in_item_t it;
    int unsigned len, r;
    // outside any chunk: pull finds nothing, pushes fill the accumulator until refused
    pull_once();
    push_raw(8'hff, 1'b0);
    push_raw(8'h00, 1'b0);
    push_raw(8'haa, 1'b0);
    push_raw(8'h55, 1'b0);
    pull_once();
    // start on a full accumulator empties it first
    push_raw(8'h41, 1'b1);
    pull_once();                            // too few bits
    // zero length chunk yields nothing
    it = '0;
    it.chunk_start = 1'b1;
    it.restart_codes = 1'b1;
    it.clear_table = 1'b1;
    add_item(it);
    pull_once();
    make_chunk(13'h1fff, 1'b1, 1'b1, 8);   // saturating length
    make_chunk(1, 1'b1, 1'b0, 4);
    make_chunk(ChunkMax, 1'b0, 1'b1, 6);
    while (stim_q.size() < 1320) begin
      r = $urandom_range(99);
      if (r < 85)      len = $urandom_range(48, 1);
      else if (r < 90) len = $urandom_range(8191, 4096);
      else if (r < 93) len = 0;
      else             len = $urandom_range(8191, 1);
      make_chunk(len, $urandom_range(99) < 85, $urandom_range(1), 140);
    end
  endfunction

  // sender: bursts with random gaps
  initial begin
    int gap, burst;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    planner.clear_all();
    build_stimulus();
    gap   = 0;
    burst = $urandom_range(20, 1);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) sb.note_input(in_item_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap > 0 || stim_q.size() == 0) begin
          if (gap > 0) gap--;
          in_valid_i <= 1'b0;
          if (stim_q.size() == 0) stim_done = 1'b1;
        end else begin
          in_item_i  <= stim_q.pop_front();
          in_valid_i <= 1'b1;
          burst--;
          if (burst <= 0) begin
            burst = $urandom_range(30, 1);
            gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
          end
        end
      end
    end
  end

  // receiver: stall mode re-picked at random from four patterns, plus one long hold
  initial begin
    int cyc, mode;
    cyc  = 0;
    mode = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
      cyc++;
      if (cyc % 200 == 0) mode = $urandom_range(3);
      if (cyc >= 3000 && cyc < 3500)
        out_stall_i <= 1'b1;                // long hold-off; input should back up
      else
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(99) < 30);
          2: out_stall_i <= cyc[0];
          default: out_stall_i <= ($urandom_range(99) < 80);
        endcase
    end
  end

  // end of run
  initial begin
    wait (rst_ni === 1'b1);
    while (!(stim_done && !in_valid_i && sb.expected_q.size() == 0)) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < 2000000) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
design/lzw_pkg.sv
design/lzw_ctrl.sv
design/lzw_dp.sv
design/lzw_chunk_decompressor.sv
design/lzw_chk.sv
dv/tb_lzw_chunk_decompressor.sv
